[hw/rtl/ieu_pkg.sv]
// Shared types, opcodes and constants for the integer execute unit.
package ieu_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [5:0] {
    OP_ADD = 6'd0, OP_ADDU = 6'd1, OP_SUB = 6'd2, OP_SUBU = 6'd3, OP_AND = 6'd4,
    OP_OR = 6'd5, OP_XOR = 6'd6, OP_SLT = 6'd7, OP_SLTU = 6'd8, OP_MULT = 6'd9,
    OP_MULTU = 6'd10, OP_DIV = 6'd11, OP_DIVU = 6'd12, OP_MFHI = 6'd13,
    OP_MFLO = 6'd14, OP_MTHI = 6'd15, OP_MTLO = 6'd16, OP_SLL = 6'd17,
    OP_SRL = 6'd18, OP_SRA = 6'd19, OP_SLLV = 6'd20, OP_SRLV = 6'd21,
    OP_SRAV = 6'd22, OP_ADDI = 6'd23, OP_ADDIU = 6'd24, OP_ANDI = 6'd25,
    OP_ORI = 6'd26, OP_XORI = 6'd27, OP_SLTI = 6'd28, OP_SLTIU = 6'd29,
    OP_LUI = 6'd30, OP_BEQ = 6'd31, OP_BNE = 6'd32, OP_BLEZ = 6'd33,
    OP_BGTZ = 6'd34, OP_BLTZ = 6'd35, OP_BGEZ = 6'd36
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_OVF = 2'd1, ST_DIVZ = 2'd2, ST_INVALID = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_ALU, S_MUL, S_DIV, S_FIX, S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture request
    logic alu;       // finish single-cycle op
    logic mul_step;  // one multiplier partial product
    logic div_step;
    logic fix;       // sign fix and HI/LO write of mul/div
  } cmd_t;

  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic last;      // iteration count reached
  } stat_t;

endpackage

[hw/rtl/ieu_ctrl.sv]
// Controller sequencing single-cycle, multiply and divide requests.
module ieu_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  ieu_pkg::stat_t  st,
  output ieu_pkg::cmd_t   cmd
);
  ieu_pkg::state_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) state <= ieu_pkg::S_IDLE;
    else state <= state_next;
  end

  // Sequence the request; a finished result can be replaced as it is taken
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ieu_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      ieu_pkg::S_ALU: begin
        cmd.alu = 1'b1;
        if (st.is_mul) state_next = ieu_pkg::S_MUL;
        else if (st.is_div) state_next = ieu_pkg::S_DIV;
        else state_next = ieu_pkg::S_DONE;
      end
      ieu_pkg::S_MUL: begin
        cmd.mul_step = 1'b1;
        if (st.last) state_next = ieu_pkg::S_FIX;
      end
      ieu_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.last) state_next = ieu_pkg::S_FIX;
      end
      ieu_pkg::S_FIX: begin
        cmd.fix = 1'b1;
        state_next = ieu_pkg::S_DONE;
      end
      ieu_pkg::S_DONE: begin
        out_valid = 1'b1;
        in_ready = out_ready;
        if (out_ready) state_next = ieu_pkg::S_IDLE;
      end
      default: state_next = ieu_pkg::S_IDLE;
    endcase
    cmd.load = in_ready && in_valid;
    if (cmd.load) state_next = ieu_pkg::S_ALU;
  end
endmodule

[hw/rtl/ieu_dp.sv]
// Datapath: request registers, ALU, shared mul/div unit and HI/LO pair.
module ieu_dp #(
  parameter int unsigned DataW = ieu_pkg::DataW
) (
  input  logic               clk,
  input  logic               rst,
  input  ieu_pkg::cmd_t      cmd,
  output ieu_pkg::stat_t     st,
  input  logic [5:0]         opcode,
  input  logic [DataW-1:0]   operand_a,
  input  logic [DataW-1:0]   operand_b,
  input  logic signed [15:0] immediate,
  input  logic [4:0]         shift_amount,
  input  logic [4:0]         rs_index,
  input  logic [4:0]         rt_index,
  input  logic [4:0]         rd_index,
  output logic [DataW-1:0]   result_value,
  output logic               write_enable,
  output logic               branch_taken,
  output logic signed [17:0] branch_offset,
  output logic [1:0]         status
);
  localparam int unsigned CntW = $clog2(DataW);

  logic [5:0] op;
  logic [DataW-1:0] a, b;
  logic [15:0] imm;
  logic [4:0] sh;
  logic rs0, rt0, rd0;
  logic [DataW-1:0] hi, lo;
  logic [DataW-1:0] ma, mb;
  logic neg_q, neg_r;
  logic [2*DataW-1:0] acc;
  logic [DataW-1:0] rem;
  logic [CntW-1:0] cnt;

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= opcode; a <= operand_a; b <= operand_b; imm <= immediate;
      sh <= shift_amount; rs0 <= (rs_index == '0); rt0 <= (rt_index == '0);
      rd0 <= (rd_index == '0);
    end
  end

  // Decode the field checks
  logic invalid;
  always_comb begin
    invalid = 1'b0;
    if (op <= ieu_pkg::OP_SLTU || (op >= ieu_pkg::OP_SLLV && op <= ieu_pkg::OP_SRAV))
      invalid = (sh != '0);
    else if (op <= ieu_pkg::OP_DIVU) invalid = !rd0 || (sh != '0);
    else if (op <= ieu_pkg::OP_MFLO) invalid = !rs0 || !rt0 || (sh != '0);
    else if (op <= ieu_pkg::OP_MTLO) invalid = !rt0 || !rd0 || (sh != '0);
    else if (op <= ieu_pkg::OP_SRA || op == ieu_pkg::OP_LUI) invalid = !rs0;
    else if (op == ieu_pkg::OP_BLEZ || op == ieu_pkg::OP_BGTZ) invalid = !rt0;
    else if (op > ieu_pkg::OP_BGEZ) invalid = 1'b1;
  end

  logic is_mult, is_multu, is_div, is_divu;
  assign is_mult  = (op == ieu_pkg::OP_MULT);
  assign is_multu = (op == ieu_pkg::OP_MULTU);
  assign is_div   = (op == ieu_pkg::OP_DIV);
  assign is_divu  = (op == ieu_pkg::OP_DIVU);
  assign st.is_mul = !invalid && (is_mult || is_multu);
  assign st.is_div = !invalid && (is_div || is_divu) && (b != '0);
  assign st.last = (cnt == CntW'(DataW - 1));

  // Single-cycle ALU
  logic [DataW-1:0] se, ze, res, sum_b, sum, sv;
  logic [4:0] samt;
  logic sub, ovf_chk, we, br, tk, lt_s, lt_u, sra_op;
  logic [1:0] stc;
  always_comb begin
    se = {{(DataW-16){imm[15]}}, imm};
    ze = {{(DataW-16){1'b0}}, imm};
    sub = (op == ieu_pkg::OP_SUB) || (op == ieu_pkg::OP_SUBU);
    sum_b = (op >= ieu_pkg::OP_ADDI) ? se : (sub ? ~b : b);
    sum = a + sum_b + {{(DataW-1){1'b0}}, sub};
    sv = (op == ieu_pkg::OP_SLTI || op == ieu_pkg::OP_SLTIU) ? se : b;
    lt_s = $signed(a) < $signed(sv);
    lt_u = a < sv;
    samt = (op >= ieu_pkg::OP_SLLV) ? a[4:0] : sh;
    sra_op = (op == ieu_pkg::OP_SRA) || (op == ieu_pkg::OP_SRAV);
    ovf_chk = 1'b0; we = 1'b1; br = 1'b0; tk = 1'b0; res = '0;
    stc = ieu_pkg::ST_OK;
    unique case (op)
      ieu_pkg::OP_ADD, ieu_pkg::OP_SUB, ieu_pkg::OP_ADDI: begin
        res = sum; ovf_chk = 1'b1;
      end
      ieu_pkg::OP_ADDU, ieu_pkg::OP_SUBU, ieu_pkg::OP_ADDIU: res = sum;
      ieu_pkg::OP_AND: res = a & b;
      ieu_pkg::OP_OR: res = a | b;
      ieu_pkg::OP_XOR: res = a ^ b;
      ieu_pkg::OP_ANDI: res = a & ze;
      ieu_pkg::OP_ORI: res = a | ze;
      ieu_pkg::OP_XORI: res = a ^ ze;
      ieu_pkg::OP_SLT, ieu_pkg::OP_SLTI: res = {{(DataW-1){1'b0}}, lt_s};
      ieu_pkg::OP_SLTU, ieu_pkg::OP_SLTIU: res = {{(DataW-1){1'b0}}, lt_u};
      ieu_pkg::OP_MFHI: res = hi;
      ieu_pkg::OP_MFLO: res = lo;
      ieu_pkg::OP_SLL, ieu_pkg::OP_SLLV: res = b << samt;
      ieu_pkg::OP_SRL, ieu_pkg::OP_SRLV, ieu_pkg::OP_SRA, ieu_pkg::OP_SRAV:
        res = sra_op ? DataW'($signed(b) >>> samt) : (b >> samt);
      ieu_pkg::OP_LUI: res = {imm, {(DataW-16){1'b0}}};
      ieu_pkg::OP_MULT, ieu_pkg::OP_MULTU, ieu_pkg::OP_MTHI, ieu_pkg::OP_MTLO:
        we = 1'b0;
      ieu_pkg::OP_DIV, ieu_pkg::OP_DIVU: begin
        we = 1'b0;
        if (b == '0) stc = ieu_pkg::ST_DIVZ;
      end
      ieu_pkg::OP_BEQ: begin br = 1'b1; we = 1'b0; tk = (a == b); end
      ieu_pkg::OP_BNE: begin br = 1'b1; we = 1'b0; tk = (a != b); end
      ieu_pkg::OP_BLEZ: begin br = 1'b1; we = 1'b0; tk = a[DataW-1] || (a == '0); end
      ieu_pkg::OP_BGTZ: begin br = 1'b1; we = 1'b0; tk = !a[DataW-1] && (a != '0); end
      ieu_pkg::OP_BLTZ: begin br = 1'b1; we = 1'b0; tk = a[DataW-1]; end
      ieu_pkg::OP_BGEZ: begin br = 1'b1; we = 1'b0; tk = !a[DataW-1]; end
      default: we = 1'b0;
    endcase
    if (ovf_chk && (a[DataW-1] == sum_b[DataW-1]) && (sum[DataW-1] != a[DataW-1]))
      stc = ieu_pkg::ST_OVF;
    if (invalid) stc = ieu_pkg::ST_INVALID;
  end

  // Shift-add multiply / restoring divide on magnitudes, one bit per cycle
  logic [DataW:0] psum;
  logic [DataW:0] trial;
  assign ma = ((is_mult || is_div) && a[DataW-1]) ? -a : a;
  assign psum = {1'b0, acc[2*DataW-1:DataW]} + (acc[0] ? {1'b0, mb} : '0);
  assign trial = {rem, acc[DataW-1]} - {1'b0, mb};

  always_ff @(posedge clk) begin
    if (rst) begin
      hi <= '0; lo <= '0;
    end else if (cmd.alu) begin
      result_value <= (stc == ieu_pkg::ST_OK && we) ? res : '0;
      write_enable <= (stc == ieu_pkg::ST_OK) && we;
      branch_taken <= (stc == ieu_pkg::ST_OK) && br && tk;
      branch_offset <= (stc == ieu_pkg::ST_OK && br) ? {imm, 2'b00} : '0;
      status <= stc;
      if (stc == ieu_pkg::ST_OK && op == ieu_pkg::OP_MTHI) hi <= a;
      if (stc == ieu_pkg::ST_OK && op == ieu_pkg::OP_MTLO) lo <= a;
      neg_q <= (is_mult || is_div) && (a[DataW-1] ^ b[DataW-1]);
      neg_r <= is_div && a[DataW-1];
      mb <= ((is_mult || is_div) && b[DataW-1]) ? -b : b;
      acc <= {{DataW{1'b0}}, ma};
      rem <= '0;
      cnt <= '0;
    end else if (cmd.mul_step) begin
      acc <= {psum, acc[DataW-1:1]};
      cnt <= cnt + 1'b1;
    end else if (cmd.div_step) begin
      if (!trial[DataW]) rem <= trial[DataW-1:0];
      else rem <= {rem[DataW-2:0], acc[DataW-1]};
      acc <= {acc[2*DataW-1:DataW], acc[DataW-2:0], !trial[DataW]};
      cnt <= cnt + 1'b1;
    end else if (cmd.fix) begin
      if (is_mult || is_multu) begin
        hi <= neg_q ? DataW'((-acc) >> DataW) : acc[2*DataW-1:DataW];
        lo <= neg_q ? DataW'(-acc) : acc[DataW-1:0];
      end else begin
        hi <= neg_r ? -rem : rem;
        lo <= neg_q ? -acc[DataW-1:0] : acc[DataW-1:0];
      end
    end
  end
endmodule

[hw/rtl/integer_execute_unit_hi_lo_unit.sv]
// Integer execute unit top level: controller plus datapath.
// Single-cycle ops, divide by zero and invalid requests go through the ALU state to the result;
// mult/multu and div/divu then run one bit a cycle, then the sign fix, before the result.
// One request in flight; the next is taken as the result leaves, so a new request
// is never taken while a result waits.
// Reset (rst, synchronous) empties the unit and clears HI and LO.
module integer_execute_unit_hi_lo_unit #(
  parameter int unsigned DataW = ieu_pkg::DataW
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [5:0]         opcode,
  input  logic [DataW-1:0]   operand_a,
  input  logic [DataW-1:0]   operand_b,
  input  logic signed [15:0] immediate,
  input  logic [4:0]         shift_amount,
  input  logic [4:0]         rs_index,
  input  logic [4:0]         rt_index,
  input  logic [4:0]         rd_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DataW-1:0]   result_value,
  output logic               write_enable,
  output logic               branch_taken,
  output logic signed [17:0] branch_offset,
  output logic [1:0]         status
);
  ieu_pkg::cmd_t  cmd;
  ieu_pkg::stat_t st;

  ieu_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .st, .cmd
  );

  ieu_dp #(.DataW(DataW)) u_dp (
    .clk, .rst, .cmd, .st, .opcode, .operand_a, .operand_b, .immediate,
    .shift_amount, .rs_index, .rt_index, .rd_index, .result_value,
    .write_enable, .branch_taken, .branch_offset, .status
  );
endmodule

[hw/rtl/ieu_checker.sv]
// Port-level checks for the integer execute unit, bound to the top level.
module ieu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        write_enable,
  input logic        branch_taken,
  input logic [1:0]  status,
  input logic [31:0] result_value
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value))
    else $error("result dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result waits");
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ieu_pkg::ST_OK |->
      !write_enable && !branch_taken && result_value == '0)
    else $error("error result not cleared");
  a_no_we_branch: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(write_enable && branch_taken))
    else $error("branch result writes register");
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
endmodule

bind integer_execute_unit_hi_lo_unit ieu_checker u_ieu_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .write_enable,
  .branch_taken, .status, .result_value
);

[test/integer_execute_unit_hi_lo_unit_tb.sv]
// Self-checking testbench for the integer execute unit with HI/LO pair.
module integer_execute_unit_hi_lo_unit_tb;

  localparam int WatchdogLimit = 4000;
  localparam int RandomCount = 750;

  typedef struct packed {
    logic [5:0]         op;
    logic [31:0]        a;
    logic [31:0]        b;
    logic signed [15:0] imm;
    logic [4:0]         sh;
    logic [4:0]         rs;
    logic [4:0]         rt;
    logic [4:0]         rd;
  } instr_t;

  typedef struct packed {
    logic [31:0] value;
    logic        we;
    logic        taken;
    logic [17:0] offs;
    logic [1:0]  st;
  } outcome_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [5:0] opcode;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  logic signed [15:0] immediate;
  logic [4:0] shift_amount;
  logic [4:0] rs_index;
  logic [4:0] rt_index;
  logic [4:0] rd_index;
  logic out_valid;
  logic out_ready;
  logic [31:0] result_value;
  logic write_enable;
  logic branch_taken;
  logic signed [17:0] branch_offset;
  logic [1:0] status;

  instr_t pending_instrs[$];
  outcome_t expected_outcomes[$];
  logic [31:0] model_hi;
  logic [31:0] model_lo;
  int errors;
  int idle_cycles;
  int gap_left;
  int stall_left;
  int hold_off;
  bit quiet_phase;
  bit drain_pause;
  bit stim_done;
  logic in_ready_seen;

  integer_execute_unit_hi_lo_unit DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .operand_a(operand_a), .operand_b(operand_b),
    .immediate(immediate), .shift_amount(shift_amount), .rs_index(rs_index),
    .rt_index(rt_index), .rd_index(rd_index), .out_valid(out_valid),
    .out_ready(out_ready), .result_value(result_value),
    .write_enable(write_enable), .branch_taken(branch_taken),
    .branch_offset(branch_offset), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Compute the outcome of one instruction and advance the HI/LO copy.
  function automatic outcome_t execute_instr(instr_t i);
    outcome_t o;
    logic [31:0] se;
    logic [31:0] ze;
    logic [31:0] res;
    logic [31:0] nhi;
    logic [31:0] nlo;
    logic [63:0] prod;
    logic [1:0] st;
    logic we;
    logic tk;
    logic br;
    bit bad;
    se = {{16{i.imm[15]}}, i.imm};
    ze = {16'h0, i.imm};
    res = '0;
    nhi = model_hi;
    nlo = model_lo;
    st = ieu_pkg::ST_OK;
    we = 1'b1;
    tk = 1'b0;
    br = 1'b0;
    bad = 0;
    // Check fields that the instruction must leave zero.
    if (i.op <= ieu_pkg::OP_SLTU || (i.op >= ieu_pkg::OP_SLLV && i.op <= ieu_pkg::OP_SRAV))
      bad = i.sh != 0;
    else if (i.op <= ieu_pkg::OP_DIVU) bad = i.rd != 0 || i.sh != 0;
    else if (i.op <= ieu_pkg::OP_MFLO) bad = i.rs != 0 || i.rt != 0 || i.sh != 0;
    else if (i.op <= ieu_pkg::OP_MTLO) bad = i.rt != 0 || i.rd != 0 || i.sh != 0;
    else if (i.op <= ieu_pkg::OP_SRA || i.op == ieu_pkg::OP_LUI) bad = i.rs != 0;
    else if (i.op == ieu_pkg::OP_BLEZ || i.op == ieu_pkg::OP_BGTZ) bad = i.rt != 0;
    else if (i.op > ieu_pkg::OP_BGEZ) bad = 1;
    if (bad) st = ieu_pkg::ST_INVALID;
    else begin
      case (ieu_pkg::op_t'(i.op))
        ieu_pkg::OP_ADD: begin
          res = i.a + i.b;
          if ((i.a[31] == i.b[31]) && (res[31] != i.a[31])) st = ieu_pkg::ST_OVF;
        end
        ieu_pkg::OP_ADDU: res = i.a + i.b;
        ieu_pkg::OP_SUB: begin
          res = i.a - i.b;
          if ((i.a[31] != i.b[31]) && (res[31] != i.a[31])) st = ieu_pkg::ST_OVF;
        end
        ieu_pkg::OP_SUBU: res = i.a - i.b;
        ieu_pkg::OP_AND: res = i.a & i.b;
        ieu_pkg::OP_OR: res = i.a | i.b;
        ieu_pkg::OP_XOR: res = i.a ^ i.b;
        ieu_pkg::OP_SLT: res = {31'h0, $signed(i.a) < $signed(i.b)};
        ieu_pkg::OP_SLTU: res = {31'h0, i.a < i.b};
        ieu_pkg::OP_MULT: begin
          prod = $signed({{32{i.a[31]}}, i.a}) * $signed({{32{i.b[31]}}, i.b});
          {nhi, nlo} = prod;
          we = 1'b0;
        end
        ieu_pkg::OP_MULTU: begin
          prod = {32'h0, i.a} * {32'h0, i.b};
          {nhi, nlo} = prod;
          we = 1'b0;
        end
        ieu_pkg::OP_DIV: begin
          we = 1'b0;
          if (i.b == 0) st = ieu_pkg::ST_DIVZ;
          else if (i.a == 32'h8000_0000 && i.b == 32'hFFFF_FFFF) begin
            nlo = 32'h8000_0000;
            nhi = '0;
          end else begin
            nlo = $signed(i.a) / $signed(i.b);
            nhi = $signed(i.a) % $signed(i.b);
          end
        end
        ieu_pkg::OP_DIVU: begin
          we = 1'b0;
          if (i.b == 0) st = ieu_pkg::ST_DIVZ;
          else begin
            nlo = i.a / i.b;
            nhi = i.a % i.b;
          end
        end
        ieu_pkg::OP_MFHI: res = model_hi;
        ieu_pkg::OP_MFLO: res = model_lo;
        ieu_pkg::OP_MTHI: begin nhi = i.a; we = 1'b0; end
        ieu_pkg::OP_MTLO: begin nlo = i.a; we = 1'b0; end
        ieu_pkg::OP_SLL: res = i.b << i.sh;
        ieu_pkg::OP_SRL: res = i.b >> i.sh;
        ieu_pkg::OP_SRA: res = $signed(i.b) >>> i.sh;
        ieu_pkg::OP_SLLV: res = i.b << i.a[4:0];
        ieu_pkg::OP_SRLV: res = i.b >> i.a[4:0];
        ieu_pkg::OP_SRAV: res = $signed(i.b) >>> i.a[4:0];
        ieu_pkg::OP_ADDI: begin
          res = i.a + se;
          if ((i.a[31] == se[31]) && (res[31] != i.a[31])) st = ieu_pkg::ST_OVF;
        end
        ieu_pkg::OP_ADDIU: res = i.a + se;
        ieu_pkg::OP_ANDI: res = i.a & ze;
        ieu_pkg::OP_ORI: res = i.a | ze;
        ieu_pkg::OP_XORI: res = i.a ^ ze;
        ieu_pkg::OP_SLTI: res = {31'h0, $signed(i.a) < $signed(se)};
        ieu_pkg::OP_SLTIU: res = {31'h0, i.a < se};
        ieu_pkg::OP_LUI: res = {i.imm, 16'h0};
        default: begin
          br = 1'b1;
          we = 1'b0;
          case (ieu_pkg::op_t'(i.op))
            ieu_pkg::OP_BEQ: tk = i.a == i.b;
            ieu_pkg::OP_BNE: tk = i.a != i.b;
            ieu_pkg::OP_BLEZ: tk = i.a[31] || i.a == 0;
            ieu_pkg::OP_BGTZ: tk = !i.a[31] && i.a != 0;
            ieu_pkg::OP_BLTZ: tk = i.a[31];
            default: tk = !i.a[31];
          endcase
        end
      endcase
    end
    o = '0;
    o.st = st;
    if (st == ieu_pkg::ST_OK) begin
      model_hi = nhi;
      model_lo = nlo;
      o.we = we;
      o.value = we ? res : '0;
      if (br) begin
        o.taken = tk;
        o.offs = {i.imm, 2'b00};
      end
    end
    return o;
  endfunction

  // Build a legal-field instruction of the given operation.
  function automatic instr_t legal_instr(logic [5:0] op);
    instr_t i;
    i.op = op;
    case ($urandom_range(0, 3))
      0: i.a = 32'h8000_0000 | ($urandom_range(0, 3));
      1: i.a = $urandom_range(0, 40) - 20;
      default: i.a = $urandom;
    endcase
    case ($urandom_range(0, 4))
      0: i.b = 32'hFFFF_FFFF;
      1: i.b = $urandom_range(0, 5);
      2: i.b = i.a;
      default: i.b = $urandom;
    endcase
    i.imm = 16'($urandom);
    i.sh = 5'($urandom);
    i.rs = 5'($urandom);
    i.rt = 5'($urandom);
    i.rd = 5'($urandom);
    if (op <= ieu_pkg::OP_SLTU || (op >= ieu_pkg::OP_SLLV && op <= ieu_pkg::OP_SRAV))
      i.sh = 0;
    else if (op <= ieu_pkg::OP_DIVU) begin i.rd = 0; i.sh = 0; end
    else if (op <= ieu_pkg::OP_MFLO) begin i.rs = 0; i.rt = 0; i.sh = 0; end
    else if (op <= ieu_pkg::OP_MTLO) begin i.rt = 0; i.rd = 0; i.sh = 0; end
    else if (op <= ieu_pkg::OP_SRA || op == ieu_pkg::OP_LUI) i.rs = 0;
    else if (op == ieu_pkg::OP_BLEZ || op == ieu_pkg::OP_BGTZ) i.rt = 0;
    return i;
  endfunction

  function automatic instr_t raw_instr(logic [5:0] op, logic [31:0] a, logic [31:0] b,
                                       logic [15:0] imm);
    instr_t i;
    i = '0;
    i.op = op;
    i.a = a;
    i.b = b;
    i.imm = imm;
    return i;
  endfunction

  // Fill the request queue: directed corners, then random traffic.
  initial begin
    instr_t i;
    pending_instrs.push_back(raw_instr(ieu_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h1, 16'h0));
    pending_instrs.push_back(raw_instr(ieu_pkg::OP_SUB, 32'h8000_0000, 32'h1, 16'h0));
    pending_instrs.push_back(raw_instr(ieu_pkg::OP_ADDI, 32'h7FFF_FFFF, 32'h0, 16'h7FFF));
    pending_instrs.push_back(raw_instr(ieu_pkg::OP_ADDI, 32'h8000_0000, 32'h0, 16'h8000));
    pending_instrs.push_back(raw_instr(ieu_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF,
                                       16'h0));
    pending_instrs.push_back(raw_instr(ieu_pkg::OP_MFHI, 32'h0, 32'h0, 16'h0));
    pending_instrs.push_back(raw_instr(ieu_pkg::OP_MFLO, 32'h0, 32'h0, 16'h0));
    pending_instrs.push_back(raw_instr(ieu_pkg::OP_DIV, 32'hFFFF_FFF9, 32'h2, 16'h0));
    pending_instrs.push_back(raw_instr(ieu_pkg::OP_DIVU, 32'h5, 32'h0, 16'h0));
    pending_instrs.push_back(raw_instr(ieu_pkg::OP_MFHI, 32'h0, 32'h0, 16'h0));
    pending_instrs.push_back(raw_instr(ieu_pkg::OP_MULTU, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                       16'h0));
    pending_instrs.push_back(raw_instr(ieu_pkg::OP_MFHI, 32'h0, 32'h0, 16'h0));
    pending_instrs.push_back(raw_instr(ieu_pkg::OP_MULT, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                       16'h0));
    pending_instrs.push_back(raw_instr(ieu_pkg::OP_MFLO, 32'h0, 32'h0, 16'h0));
    pending_instrs.push_back(raw_instr(ieu_pkg::OP_LUI, 32'h0, 32'h0, 16'hFFFF));
    pending_instrs.push_back(raw_instr(ieu_pkg::OP_BEQ, 32'h5, 32'h5, 16'h8000));
    pending_instrs.push_back(raw_instr(ieu_pkg::OP_BNE, 32'h5, 32'h5, 16'h7FFF));
    pending_instrs.push_back(raw_instr(ieu_pkg::OP_SLTIU, 32'h1, 32'h0, 16'hFFFF));
    pending_instrs.push_back(raw_instr(ieu_pkg::OP_SRA, 32'h0, 32'h8000_0000, 16'h0));
    i = raw_instr(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    i.sh = 5'h1F; i.rs = 5'h1F; i.rt = 5'h1F; i.rd = 5'h1F;
    pending_instrs.push_back(i);
    i = raw_instr(ieu_pkg::OP_MTHI, 32'h1234_5678, 32'h0, 16'h0);
    i.rd = 5'h3;
    pending_instrs.push_back(i);
    for (int n = 0; n < RandomCount; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        i.op = 6'($urandom);
        i.a = $urandom; i.b = $urandom; i.imm = 16'($urandom);
        i.sh = 5'($urandom); i.rs = 5'($urandom); i.rt = 5'($urandom);
        i.rd = 5'($urandom);
      end else begin
        i = legal_instr(6'($urandom_range(ieu_pkg::OP_ADD, ieu_pkg::OP_BGEZ)));
        // Keep long multiply/divide ops rarer than single-cycle ones.
        if (i.op >= ieu_pkg::OP_MULT && i.op <= ieu_pkg::OP_DIVU &&
            $urandom_range(0, 2) != 0)
          i = legal_instr(ieu_pkg::OP_ADDU);
      end
      pending_instrs.push_back(i);
    end
  end

  // Drive requests at the falling edge, with random gaps and one drain pause.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready_seen) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (drain_pause && expected_outcomes.size() != 0) begin
        in_valid <= 1'b0;
      end else if (pending_instrs.size() == 0) begin
        in_valid <= 1'b0;
        stim_done <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        gap_left <= $urandom_range(1, 9) - 1;
        in_valid <= 1'b0;
      end else begin
        instr_t i;
        i = pending_instrs.pop_front();
        drain_pause <= 1'b0;
        in_valid <= 1'b1;
        opcode <= i.op; operand_a <= i.a; operand_b <= i.b; immediate <= i.imm;
        shift_amount <= i.sh; rs_index <= i.rs; rt_index <= i.rt; rd_index <= i.rd;
      end
    end
  end

  // Remember whether the request on the pins was taken at the last rising edge.
  always @(posedge clk) begin
    if (rst) in_ready_seen <= 1'b0;
    else in_ready_seen <= in_valid && in_ready;
  end

  // Drive result-side stalls at the falling edge, with one long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(1, 9) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Predict on accept, compare on each delivered result.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        instr_t i;
        i = '{opcode, operand_a, operand_b, immediate, shift_amount,
              rs_index, rt_index, rd_index};
        expected_outcomes.push_back(execute_instr(i));
      end
      if (out_valid && out_ready) begin
        outcome_t e;
        if (expected_outcomes.size() == 0) begin
          $display("%0t: unexpected result value=%h status=%0d", $time,
                   result_value, status);
          errors++;
        end else begin
          e = expected_outcomes.pop_front();
          if (result_value !== e.value) begin
            $display("%0t: result_value expected %h actual %h", $time, e.value,
                     result_value);
            errors++;
          end
          if (write_enable !== e.we) begin
            $display("%0t: write_enable expected %b actual %b", $time, e.we,
                     write_enable);
            errors++;
          end
          if (branch_taken !== e.taken) begin
            $display("%0t: branch_taken expected %b actual %b", $time, e.taken,
                     branch_taken);
            errors++;
          end
          if (branch_offset !== e.offs) begin
            $display("%0t: branch_offset expected %h actual %h", $time, e.offs,
                     branch_offset);
            errors++;
          end
          if (status !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, status);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // Reset, pressure phases and end of run.
  initial begin
    errors = 0;
    idle_cycles = 0;
    gap_left = 0;
    stall_left = 0;
    hold_off = 0;
    quiet_phase = 0;
    drain_pause = 0;
    stim_done = 0;
    model_hi = '0;
    model_lo = '0;
    in_valid = 0;
    out_ready = 0;
    opcode = '0; operand_a = '0; operand_b = '0; immediate = '0;
    shift_amount = '0; rs_index = '0; rt_index = '0; rd_index = '0;
    rst = 1;
    repeat (2) @(posedge clk);
    rst <= 0;
    fork
      begin
        wait (pending_instrs.size() < RandomCount - 100);
        @(posedge clk) hold_off <= 60;
        wait (pending_instrs.size() < RandomCount - 250);
        @(posedge clk) drain_pause <= 1'b1;
        wait (pending_instrs.size() < 120);
        quiet_phase = 1;
        wait (stim_done && expected_outcomes.size() == 0);
        repeat (40) @(posedge clk);
      end
      wait (idle_cycles >= WatchdogLimit);
    join_any
    if (idle_cycles >= WatchdogLimit || expected_outcomes.size() != 0 || errors != 0)
      $display("RESULT: ERROR");
    else
      $display("RESULT: OK");
    $finish;
  end

endmodule

[files.f]
hw/rtl/ieu_pkg.sv
hw/rtl/ieu_ctrl.sv
hw/rtl/ieu_dp.sv
hw/rtl/integer_execute_unit_hi_lo_unit.sv
hw/rtl/ieu_checker.sv
test/integer_execute_unit_hi_lo_unit_tb.sv
